FILE: rtl/core/sstq_pkg.sv
// ----------------------------------------------------------------------------
// sstq_pkg
// Types and constants shared by the sorted sleep timer queue.
// ----------------------------------------------------------------------------
package sstq_pkg;

	localparam int ID_W   = 8;
	localparam int DUR_W  = 32;
	localparam int TICK_W = 64;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	localparam logic KIND_SLEEP = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	localparam logic ST_WOKEN  = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef struct packed {
		logic               is_tick;
		logic [ID_W-1:0]    task_id;
		logic [DUR_W-2:0]   duration;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] woken_id;
		logic            status;
		logic            last;
	} res_t;

endpackage

FILE: rtl/core/sstq_ifs.sv
// ----------------------------------------------------------------------------
// sstq_ifs
// Request and result channels of the sorted sleep timer queue.
// ----------------------------------------------------------------------------
interface sstq_req_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic [sstq_pkg::ID_W-1:0]         task_id;
	logic signed [sstq_pkg::DUR_W-1:0] duration;

	modport source (output valid, output kind, output task_id, output duration, input ready);
	modport sink (input valid, input kind, input task_id, input duration, output ready);
endinterface

interface sstq_res_if;
	logic                      valid;
	logic                      ready;
	logic [sstq_pkg::ID_W-1:0] woken_id;
	logic                      status;
	logic                      last;

	modport source (output valid, output woken_id, output status, output last, input ready);
	modport sink (input valid, input woken_id, input status, input last, output ready);
endinterface

FILE: rtl/core/sstq_front.sv
// ----------------------------------------------------------------------------
// sstq_front
// Accepts requests, drops sleeps with no positive duration and queues the
// rest as commands for the back end.
// ----------------------------------------------------------------------------
module sstq_front (
	input  logic            clk,
	input  logic            arst_n,
	sstq_req_if.sink        req,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output sstq_pkg::cmd_t  cmd
);

	sstq_pkg::cmd_t                         fifo_q [sstq_pkg::FIFO_DEPTH];
	logic [sstq_pkg::FIFO_PTR_W-1:0]        wr_ptr_q;
	logic [sstq_pkg::FIFO_PTR_W-1:0]        rd_ptr_q;
	logic [sstq_pkg::FIFO_CNT_W-1:0]        cnt_q;
	sstq_pkg::cmd_t                         new_cmd;
	logic                                   keep;
	logic                                   push;
	logic                                   pop;

	assign req.ready = (cnt_q != sstq_pkg::FIFO_CNT_W'(sstq_pkg::FIFO_DEPTH));
	assign keep      = (req.kind == sstq_pkg::KIND_TICK) ||
	                   ((req.duration != '0) && !req.duration[sstq_pkg::DUR_W-1]);
	assign push      = req.valid && req.ready && keep;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_comb begin
		new_cmd.is_tick  = (req.kind == sstq_pkg::KIND_TICK);
		new_cmd.task_id  = req.task_id;
		new_cmd.duration = req.duration[sstq_pkg::DUR_W-2:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sstq_pkg::FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sstq_pkg::FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + sstq_pkg::FIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - sstq_pkg::FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/sstq_back.sv
// ----------------------------------------------------------------------------
// sstq_back
// Keeps the tick count and the sorted store of sleeping tasks. Inserts sleeps
// in one shift step; pops due tasks on a tick, one per cycle when not stalled.
// ----------------------------------------------------------------------------
module sstq_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  sstq_pkg::cmd_t  cmd,
	sstq_res_if.source      res
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_INSERT,
		S_POP
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                count_q;
	logic [sstq_pkg::TICK_W-1:0]     tick_q;
	logic [sstq_pkg::TICK_W-1:0]     wake_new_q;
	logic [sstq_pkg::ID_W-1:0]       id_new_q;
	logic                            out_valid_q;
	sstq_pkg::res_t                  res_q;

	logic [sstq_pkg::TICK_W-1:0]     wake_q [QUEUE_DEPTH];
	logic [sstq_pkg::ID_W-1:0]       task_q [QUEUE_DEPTH];
	logic [sstq_pkg::TICK_W-1:0]     prev_wake_w [QUEUE_DEPTH];
	logic [sstq_pkg::ID_W-1:0]       prev_task_w [QUEUE_DEPTH];
	logic [sstq_pkg::TICK_W-1:0]     next_wake_w [QUEUE_DEPTH];
	logic [sstq_pkg::ID_W-1:0]       next_task_w [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]          move;
	logic [QUEUE_DEPTH-1:0]          from_prev;

	logic                            out_free;
	logic                            full;
	logic                            head_due;
	logic                            next_due;
	logic                            pop_fire;
	logic                            cmd_fire;

	assign out_free  = !out_valid_q || res.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_due  = (count_q != '0) && (wake_q[0] <= tick_q);
	assign pop_fire  = (state_q == S_POP) && head_due && out_free;
	assign cmd_ready = (state_q == S_IDLE) && (cmd.is_tick || !full || out_free);
	assign cmd_fire  = cmd_valid && cmd_ready;

	generate
		if (QUEUE_DEPTH > 1) begin : g_next_due
			assign next_due = (count_q > CNT_W'(1)) && (wake_q[1] <= tick_q);
		end else begin : g_no_next_due
			assign next_due = 1'b0;
		end
	endgenerate

	generate
		for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			assign move[i] = (CNT_W'(i) < count_q) && (wake_q[i] > wake_new_q);

			if (i == 0) begin : g_first
				assign from_prev[i]   = 1'b0;
				assign prev_wake_w[i] = wake_new_q;
				assign prev_task_w[i] = id_new_q;
			end else begin : g_mid
				assign from_prev[i]   = move[i-1];
				assign prev_wake_w[i] = wake_q[i-1];
				assign prev_task_w[i] = task_q[i-1];
			end

			if (i == QUEUE_DEPTH - 1) begin : g_tail
				assign next_wake_w[i] = wake_q[i];
				assign next_task_w[i] = task_q[i];
			end else begin : g_body
				assign next_wake_w[i] = wake_q[i+1];
				assign next_task_w[i] = task_q[i+1];
			end

			always_ff @(posedge clk) begin
				if (state_q == S_INSERT) begin
					if (from_prev[i]) begin
						wake_q[i] <= prev_wake_w[i];
						task_q[i] <= prev_task_w[i];
					end else if (move[i] || (count_q == CNT_W'(i))) begin
						wake_q[i] <= wake_new_q;
						task_q[i] <= id_new_q;
					end
				end else if (pop_fire) begin
					wake_q[i] <= next_wake_w[i];
					task_q[i] <= next_task_w[i];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			tick_q      <= '0;
			wake_new_q  <= '0;
			id_new_q    <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						if (cmd.is_tick) begin
							tick_q  <= tick_q + sstq_pkg::TICK_W'(1);
							state_q <= S_POP;
						end else if (full) begin
							out_valid_q    <= 1'b1;
							res_q.woken_id <= cmd.task_id;
							res_q.status   <= sstq_pkg::ST_REJECT;
							res_q.last     <= 1'b1;
						end else begin
							wake_new_q <= tick_q + sstq_pkg::TICK_W'(cmd.duration);
							id_new_q   <= cmd.task_id;
							state_q    <= S_INSERT;
						end
					end
				end
				S_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_IDLE;
				end
				S_POP: begin
					if (!head_due) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q    <= 1'b1;
						res_q.woken_id <= task_q[0];
						res_q.status   <= sstq_pkg::ST_WOKEN;
						res_q.last     <= !next_due;
						count_q        <= count_q - CNT_W'(1);
						if (!next_due) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid    = out_valid_q;
	assign res.woken_id = res_q.woken_id;
	assign res.status   = res_q.status;
	assign res.last     = res_q.last;

endmodule

FILE: rtl/core/sorted_sleep_timer_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_sleep_timer_queue_core
// Sorted sleep timer queue: a tick counter and a wakeup-ordered task store.
// ----------------------------------------------------------------------------
// A request is either a sleep (task id and signed duration) or a tick. A sleep
// with zero or negative duration is dropped in the front end and takes no
// back-end time; any other sleep is handled in the back end as a wakeup sum,
// then one parallel shift-insert into the sorted store, or as one rejection
// result when all QUEUE_DEPTH entries are in use. A tick increments the tick
// count, then the store pops each task that falls due into the result
// register, one entry per cycle while the result side is free, earliest
// first, with last set on the final one. A two-entry command queue lets
// requests keep arriving while the back end works or the result side stalls.
// ----------------------------------------------------------------------------
module sorted_sleep_timer_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sstq_req_if.sink    req,
	sstq_res_if.source  res
);

	logic            cmd_valid;
	logic            cmd_ready;
	sstq_pkg::cmd_t  cmd;

	sstq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	sstq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res       (res)
	);

endmodule
